@@ hw/rtl/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int CoordWidth  = 8;
    localparam int CharWidth   = 8;
    localparam int ApbAddrW    = 3;
    localparam int ApbDataW    = 32;
    localparam int SDataW      = 8;
    localparam int MDataW      = 32;

    localparam logic [CharWidth-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CharWidth-1:0] CODE_RETURN    = 8'd13;
    localparam logic [CharWidth-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CharWidth-1:0] PRINT_LOW      = 8'd32;
    localparam logic [CharWidth-1:0] PRINT_HIGH     = 8'd126;

    localparam logic [CoordWidth-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [CoordWidth-1:0] ROWS_RESET    = 8'd25;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_ERASE = 2'd2
    } cell_action_t;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CoordWidth-1:0] columns;
        logic [CoordWidth-1:0] rows;
    } geom_t;

    typedef struct packed {
        cell_action_t          cell_action;
        logic [CharWidth-1:0]  glyph_code;
        logic [CoordWidth-1:0] cell_column;
        logic [CoordWidth-1:0] cell_row;
        logic                  scroll_up;
    } result_t;

endpackage

@@ hw/rtl/text_console_cursor_engine_unit.sv @@
// Text console cursor engine: one character byte in, one cell command out per beat.
// Takes a new character every cycle while the output buffer has room; each command is
// registered on its way out to m_tdata. The cursor update is a handful of compares and
// increments on the column and row registers, done in the cycle of acceptance, and a
// two-entry output buffer lets input continue for one beat while the sink stalls.
// Depends on tcce_pkg, tcce_regs, tcce_cursor and tcce_skid.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcce_pkg::ApbAddrW-1:0]  paddr,
    input  logic [tcce_pkg::ApbDataW-1:0]  pwdata,
    output logic [tcce_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    // character stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcce_pkg::SDataW-1:0]    s_tdata,  // [7:0] char_code
    // cell command stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcce_pkg::MDataW-1:0]    m_tdata,  // [7:0] glyph_code, [15:8] cell_column,
                                                     // [23:16] cell_row, [24] scroll_up,
                                                     // [31:25] zero
    output logic [1:0]                     m_tuser   // [1:0] cell_action
);
    import tcce_pkg::*;

    geom_t   geom;
    result_t cur_res;
    result_t out_res;
    logic    accept;

    assign accept = s_tvalid & s_tready;

    tcce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    tcce_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata[CharWidth-1:0]),
        .geom      (geom),
        .res       (cur_res)
    );

    tcce_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (cur_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(MDataW-CharWidth-2*CoordWidth-1){1'b0}}, out_res.scroll_up,
                      out_res.cell_row, out_res.cell_column, out_res.glyph_code};
    assign m_tuser = out_res.cell_action;

endmodule

@@ hw/rtl/tcce_regs.sv @@
// APB register file holding the screen geometry (columns, rows).
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcce_pkg::ApbAddrW-1:0]  paddr,
    input  logic [tcce_pkg::ApbDataW-1:0]  pwdata,
    output logic [tcce_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    output tcce_pkg::geom_t                geom
);
    import tcce_pkg::*;

    logic [CoordWidth-1:0] columns_reg, columns_next;
    logic [CoordWidth-1:0] rows_reg, rows_next;
    logic                  wr_en;
    reg_index_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_index_t'(paddr[2]);

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COLUMNS: columns_next = pwdata[CoordWidth-1:0];
                REG_ROWS:    rows_next    = pwdata[CoordWidth-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COLUMNS: prdata = {{(ApbDataW-CoordWidth){1'b0}}, columns_reg};
            REG_ROWS:    prdata = {{(ApbDataW-CoordWidth){1'b0}}, rows_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    assign geom.columns = columns_reg;
    assign geom.rows    = rows_reg;

endmodule

@@ hw/rtl/tcce_cursor.sv @@
// Cursor state and per-character command logic.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_cursor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [tcce_pkg::CharWidth-1:0]   char_code,
    input  tcce_pkg::geom_t                  geom,
    output tcce_pkg::result_t                res
);
    import tcce_pkg::*;

    logic [CoordWidth-1:0] col_reg, col_next;
    logic [CoordWidth-1:0] row_reg, row_next;
    logic [CoordWidth-1:0] ncols, nrows;
    logic [CoordWidth-1:0] col_c, row_c;
    logic [CoordWidth:0]   col_inc, row_inc;
    logic                  last_row;
    logic                  printable;

    // zero geometry acts as one
    assign ncols = (geom.columns == '0) ? CoordWidth'(1) : geom.columns;
    assign nrows = (geom.rows == '0) ? CoordWidth'(1) : geom.rows;

    // clamp a cursor left outside a shrunken screen
    assign col_c = (col_reg >= ncols) ? ncols - CoordWidth'(1) : col_reg;
    assign row_c = (row_reg >= nrows) ? nrows - CoordWidth'(1) : row_reg;

    assign col_inc   = {1'b0, col_c} + (CoordWidth+1)'(1);
    assign row_inc   = {1'b0, row_c} + (CoordWidth+1)'(1);
    assign last_row  = row_inc >= {1'b0, nrows};
    assign printable = (char_code >= PRINT_LOW) && (char_code <= PRINT_HIGH);

    always_comb
    begin
        col_next        = col_c;
        row_next        = row_c;
        res.cell_action = ACT_NONE;
        res.glyph_code  = '0;
        res.cell_column = '0;
        res.cell_row    = '0;
        res.scroll_up   = 1'b0;
        if (char_code == CODE_NEWLINE)
        begin
            col_next      = '0;
            row_next      = last_row ? row_c : row_inc[CoordWidth-1:0];
            res.scroll_up = last_row;
        end
        else if (char_code == CODE_RETURN)
        begin
            col_next = '0;
        end
        else if (char_code == CODE_BACKSPACE)
        begin
            if (col_c != '0)
            begin
                col_next        = col_c - CoordWidth'(1);
                res.cell_action = ACT_ERASE;
                res.cell_column = col_c - CoordWidth'(1);
                res.cell_row    = row_c;
            end
            else if (row_c != '0)
            begin
                col_next        = ncols - CoordWidth'(1);
                row_next        = row_c - CoordWidth'(1);
                res.cell_action = ACT_ERASE;
                res.cell_column = ncols - CoordWidth'(1);
                res.cell_row    = row_c - CoordWidth'(1);
            end
        end
        else if (printable)
        begin
            res.cell_action = ACT_DRAW;
            res.glyph_code  = char_code;
            res.cell_column = col_c;
            res.cell_row    = row_c;
            if (col_inc >= {1'b0, ncols})
            begin
                // wrap to the next row
                col_next      = '0;
                row_next      = last_row ? row_c : row_inc[CoordWidth-1:0];
                res.scroll_up = last_row;
            end
            else
            begin
                col_next = col_inc[CoordWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ hw/rtl/tcce_skid.sv @@
// Output register with a skid stage for the result stream.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcce_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcce_pkg::result_t   out_data
);
    import tcce_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    push, pop;

    assign in_ready = ~skid_valid_reg;
    assign push     = in_valid & in_ready;
    assign pop      = main_valid_reg & out_ready;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // advance the held beat once the sink takes the current one
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

@@ hw/rtl/tcce_checker.sv @@
// Port-level checks for the cursor engine, bound onto the top level.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
`timescale 1ns / 1ps

module tcce_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tcce_pkg::MDataW-1:0]    m_tdata,
    input  logic [1:0]                     m_tuser
);
    import tcce_pkg::*;

    // hold a stalled beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result beat dropped");

    // no cell coordinates without a cell command
    a_idle_coords: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_NONE |-> m_tdata[23:8] == '0)
        else $error("coordinates set on a beat with no cell command");

    // glyph only travels with a draw
    a_glyph_draw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ACT_DRAW |-> m_tdata[7:0] == '0)
        else $error("glyph code set on a beat that draws nothing");

    // erase never scrolls, and the action code is always meaningful
    a_erase_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ACT_NONE || m_tuser == ACT_DRAW
                      || (m_tuser == ACT_ERASE && !m_tdata[24])))
        else $error("bad action code or scroll on erase");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/tb_text_console_cursor_engine_unit.sv @@
// Self-checking testbench for text_console_cursor_engine_unit: directed table, then random text.
// Depends on tcce_pkg and the RTL of the block; cursor and cell commands are predicted here.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;

    import tcce_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASES        = 12;
    localparam int unsigned CHARS_PER_PHASE = 170;

    localparam result_t NOTHING = '{ACT_NONE, 8'd0, 8'd0, 8'd0, 1'b0};

    typedef struct {
        bit         is_cfg;
        reg_index_t reg_sel;
        logic [7:0] value;    // char_code, or register value for a write
        bit         pinned;
        result_t    want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MDataW-1:0]   m_tdata;
    logic [1:0]          m_tuser;

    // predicted screen geometry and cursor
    logic [7:0]  geom_cols;
    logic [7:0]  geom_rows;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;

    result_t     cmds_due[$];
    plan_row_t   plan[$];
    bit          pin_valid;
    result_t     pin_result;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned cycles;

    text_console_cursor_engine_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the predicted cursor by one character and return its cell command.
    function automatic result_t cursor_step(input logic [7:0] c);
        logic [7:0] ncols;
        logic [7:0] nrows;
        result_t    cmd;
        bit         down;
        ncols = (geom_cols == 8'd0) ? 8'd1 : geom_cols;
        nrows = (geom_rows == 8'd0) ? 8'd1 : geom_rows;
        cmd   = NOTHING;
        down  = 1'b0;
        if (cur_col >= ncols)
            cur_col = ncols - 8'd1;
        if (cur_row >= nrows)
            cur_row = nrows - 8'd1;
        if (c == CODE_NEWLINE)
        begin
            cur_col = 8'd0;
            down    = 1'b1;
        end
        else if (c == CODE_RETURN)
        begin
            cur_col = 8'd0;
        end
        else if (c == CODE_BACKSPACE)
        begin
            if (cur_col != 8'd0 || cur_row != 8'd0)
            begin
                if (cur_col != 8'd0)
                    cur_col = cur_col - 8'd1;
                else
                begin
                    cur_col = ncols - 8'd1;
                    cur_row = cur_row - 8'd1;
                end
                cmd.cell_action = ACT_ERASE;
                cmd.cell_column = cur_col;
                cmd.cell_row    = cur_row;
            end
        end
        else if (c >= PRINT_LOW && c <= PRINT_HIGH)
        begin
            cmd.cell_action = ACT_DRAW;
            cmd.glyph_code  = c;
            cmd.cell_column = cur_col;
            cmd.cell_row    = cur_row;
            cur_col = cur_col + 8'd1;
            if (cur_col >= ncols)
            begin
                cur_col = 8'd0;
                down    = 1'b1;
            end
        end
        if (down)
        begin
            // hold the row at the bottom and ask for a scroll
            if ({1'b0, cur_row} + 9'd1 >= {1'b0, nrows})
            begin
                cur_row       = nrows - 8'd1;
                cmd.scroll_up = 1'b1;
            end
            else
                cur_row = cur_row + 8'd1;
        end
        return cmd;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Compare outgoing cell commands, then record the beat taken on the input side.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1)
        begin
            if (m_tvalid && m_tready)
            begin
                got.cell_action = cell_action_t'(m_tuser);
                got.glyph_code  = m_tdata[7:0];
                got.cell_column = m_tdata[15:8];
                got.cell_row    = m_tdata[23:16];
                got.scroll_up   = m_tdata[24];
                if (cmds_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: cell command with none expected, got %h/%h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = cmds_due.pop_front();
                    check_field("cell_action", want.cell_action, got.cell_action);
                    check_field("glyph_code", want.glyph_code, got.glyph_code);
                    check_field("cell_column", want.cell_column, got.cell_column);
                    check_field("cell_row", want.cell_row, got.cell_row);
                    check_field("scroll_up", want.scroll_up, got.scroll_up);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = cursor_step(s_tdata);
                if (pin_valid)
                    want = pin_result;
                cmds_due.push_back(want);
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // All tasks start and end just after a falling edge.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_COLUMNS)
            geom_cols = val;
        else
            geom_rows = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending and wait until every command has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cmds_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
        else if (roll < 67)
            return CODE_NEWLINE;
        else if (roll < 75)
            return CODE_RETURN;
        else if (roll < 88)
            return CODE_BACKSPACE;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_geom(input int unsigned phase);
        case (phase % 4)
            0:       return 8'($urandom_range(6, 1));
            1:       return ($urandom_range(1) != 0) ? 8'd255 : 8'd1;
            2:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(12, 1));
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        geom_cols     = COLUMNS_RESET;
        geom_rows     = ROWS_RESET;
        cur_col       = 8'd0;
        cur_row       = 8'd0;
        pin_valid     = 1'b0;
        pin_result    = NOTHING;
        send_idle_pct = 30;
        recv_idle_pct = 59;
        mismatches    = 0;
        cycles        = 0;

        // reset geometry is 80 x 25, cursor at the origin
        plan.push_back('{1'b0, REG_COLUMNS, CODE_BACKSPACE, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd65, 1'b1, '{ACT_DRAW, 8'd65, 8'd0, 8'd0, 1'b0}});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd32, 1'b1, '{ACT_DRAW, 8'd32, 8'd1, 8'd0, 1'b0}});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd126, 1'b1,
                         '{ACT_DRAW, 8'd126, 8'd2, 8'd0, 1'b0}});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd127, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd31, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd0, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd255, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_BACKSPACE, 1'b1,
                         '{ACT_ERASE, 8'd0, 8'd2, 8'd0, 1'b0}});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_RETURN, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b1, NOTHING});
        // backspace from the start of a row wraps to the end of the row above
        plan.push_back('{1'b0, REG_COLUMNS, CODE_BACKSPACE, 1'b1,
                         '{ACT_ERASE, 8'd0, 8'd79, 8'd0, 1'b0}});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd90, 1'b1, '{ACT_DRAW, 8'd90, 8'd0, 8'd2, 1'b0}});
        // zero geometry acts as a single cell; cursor is pulled back into it
        plan.push_back('{1'b1, REG_COLUMNS, 8'd0, 1'b0, NOTHING});
        plan.push_back('{1'b1, REG_ROWS, 8'd0, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd120, 1'b1,
                         '{ACT_DRAW, 8'd120, 8'd0, 8'd0, 1'b1}});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b1,
                         '{ACT_NONE, 8'd0, 8'd0, 8'd0, 1'b1}});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_BACKSPACE, 1'b1, NOTHING});
        plan.push_back('{1'b1, REG_COLUMNS, 8'd255, 1'b0, NOTHING});
        plan.push_back('{1'b1, REG_ROWS, 8'd255, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b1, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_BACKSPACE, 1'b1,
                         '{ACT_ERASE, 8'd0, 8'd254, 8'd0, 1'b0}});
        // shrink to 3 x 2 with the cursor far right, then wrap on the bottom row
        plan.push_back('{1'b1, REG_COLUMNS, 8'd3, 1'b0, NOTHING});
        plan.push_back('{1'b1, REG_ROWS, 8'd2, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd97, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd98, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd99, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, 8'd100, 1'b0, NOTHING});
        plan.push_back('{1'b0, REG_COLUMNS, CODE_NEWLINE, 1'b0, NOTHING});

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].reg_sel, plan[i].value);
            end
            else
            begin
                pin_valid  = plan[i].pinned;
                pin_result = plan[i].want;
                send_char(plan[i].value);
            end
        end
        pin_valid = 1'b0;

        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 4)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain();
            write_reg(REG_COLUMNS, pick_geom(phase));
            write_reg(REG_ROWS, pick_geom(phase + 1));
            repeat (CHARS_PER_PHASE) send_char(pick_char());
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && cmds_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_regs.sv
hw/rtl/tcce_cursor.sv
hw/rtl/tcce_skid.sv
hw/rtl/text_console_cursor_engine_unit.sv
hw/rtl/tcce_checker.sv
verif/tb_text_console_cursor_engine_unit.sv
